/* src/assert_macros.svh */
// Assertion macros for the RTL of the depth-first walk block.
// Depends on nothing; the user module must declare clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define CHK_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle is followed by a consequence in the next.
`define CHK_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

/* src/gdfw_pkg.sv */
// Package for the depth-first walk block: transaction payload types,
// mode codes and the sequencer state type. Depends on nothing.
package gdfw_pkg;

	localparam int FIELD_W = 5;
	localparam logic [FIELD_W-1:0] VCOUNT_RESET = 5'd16;

	typedef enum logic [1:0] {
		MODE_CLEAR = 2'd0,
		MODE_ADD   = 2'd1,
		MODE_WALK  = 2'd2
	} mode_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [FIELD_W-1:0] vertex_a;
		logic [FIELD_W-1:0] vertex_b;
	} in_item_t;

	typedef struct packed {
		logic [FIELD_W-1:0] visited_vertex;
		logic               last;
	} out_item_t;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_POP    = 6'b000010,
		ST_CHECK  = 6'b000100,
		ST_EMIT   = 6'b001000,
		ST_SCAN   = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

endpackage

/* src/graph_depth_first_walk_top.sv */
// Depth-first walk over an undirected graph held as an adjacency bit matrix.
// Depends on gdfw_pkg and assert_macros.svh.
//
// Channel  | Direction | Handshake                  | Payload
// item     | in        | item_valid / item_ready    | gdfw_pkg::in_item_t
// result   | out       | result_valid / result_ready| gdfw_pkg::out_item_t
// cfg      | in        | cfg_we                     | cfg_data (vertex count)
//
// Clear and add complete in the idle state when the item is accepted. A walk
// pops and checks stack entries and scans all C live vertices as neighbours of
// each newly visited vertex, one neighbour per cycle.
// Each visit result leaves through one output register; the final vertex is
// held back until the walk ends so that it can carry the last flag.
// A stalled result port holds the sequencer at its next emission.
// Reset clears the matrix, the marks and the stack pointer at once.
module graph_depth_first_walk_top #(
	parameter int MAX_VERTICES = 16,
	parameter int STACK_DEPTH  = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  gdfw_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output gdfw_pkg::out_item_t result,
	input  logic                cfg_we,
	input  logic [4:0]          cfg_data
);
	import gdfw_pkg::*;
	`include "assert_macros.svh"

	localparam int VW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW   = $clog2(MAX_VERTICES + 1);
	localparam int VCW  = (CW > FIELD_W) ? CW : FIELD_W;
	localparam int SAW  = $clog2(STACK_DEPTH);
	localparam int SPW  = $clog2(STACK_DEPTH + 1);

	state_t                  state_q;
	logic [FIELD_W-1:0]      vcount_q;
	logic [MAX_VERTICES-1:0] adj_q [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] marks_q;
	logic [VW-1:0]           stack_mem [STACK_DEPTH];
	logic [VW-1:0]           rd_q;
	logic [SPW-1:0]          sp_q;
	logic [VW-1:0]           cur_u_q;
	logic [VW-1:0]           scan_v_q;
	logic [VW-1:0]           hold_q;
	logic                    hold_valid_q;
	logic                    out_valid_q;
	out_item_t               out_q;

	logic [VCW-1:0] cnt;
	logic [VCW-1:0] a_ext;
	logic [VCW-1:0] b_ext;
	logic           a_ok;
	logic           b_ok;
	logic [VW-1:0]  idx_a;
	logic [VW-1:0]  idx_b;
	logic           accept;
	logic           out_free;
	logic           out_load;
	logic           stack_full;
	logic           push_en;
	logic           scan_end;
	logic           chk_visit;
	logic           wr_en;
	logic [SAW-1:0] wr_addr;
	logic [VW-1:0]  wr_data;
	logic           rd_en;
	logic [SAW-1:0] rd_addr;

	always_comb begin
		if (VCW'(vcount_q) > VCW'(MAX_VERTICES)) begin
			cnt = VCW'(MAX_VERTICES);
		end else begin
			cnt = VCW'(vcount_q);
		end
	end

	assign a_ext      = VCW'(item.vertex_a);
	assign b_ext      = VCW'(item.vertex_b);
	assign a_ok       = (item.vertex_a != '0) && (a_ext <= cnt);
	assign b_ok       = (item.vertex_b != '0) && (b_ext <= cnt);
	assign idx_a      = VW'(a_ext - VCW'(1));
	assign idx_b      = VW'(b_ext - VCW'(1));
	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign out_free   = !out_valid_q || result_ready;
	assign out_load   = out_free && (((state_q == ST_EMIT) && hold_valid_q)
		|| (state_q == ST_FINISH));
	assign stack_full = (sp_q == SPW'(STACK_DEPTH));
	assign push_en    = (state_q == ST_SCAN) && adj_q[cur_u_q][scan_v_q]
		&& !marks_q[scan_v_q] && !stack_full;
	assign scan_end   = (VCW'(scan_v_q) == cnt - VCW'(1));
	assign chk_visit  = (VCW'(rd_q) < cnt) && !marks_q[rd_q];

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = sp_q[SAW-1:0];
		wr_data = scan_v_q;
		if (accept && item.mode == MODE_WALK && a_ok) begin
			wr_en   = 1'b1;
			wr_addr = '0;
			wr_data = idx_a;
		end else if (push_en) begin
			wr_en = 1'b1;
		end
	end

	assign rd_en   = (state_q == ST_POP) && (sp_q != '0);
	assign rd_addr = SAW'(sp_q - SPW'(1));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= stack_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			vcount_q     <= VCOUNT_RESET;
			marks_q      <= '0;
			sp_q         <= '0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int r = 0; r < MAX_VERTICES; r++) begin
				adj_q[r] <= '0;
			end
		end else begin
			if (cfg_we) begin
				vcount_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (item.mode)
							MODE_CLEAR: begin
								for (int r = 0; r < MAX_VERTICES; r++) begin
									adj_q[r] <= '0;
								end
							end
							MODE_ADD: begin
								if (a_ok && b_ok) begin
									adj_q[idx_a][idx_b] <= 1'b1;
									adj_q[idx_b][idx_a] <= 1'b1;
								end
							end
							MODE_WALK: begin
								if (a_ok) begin
									marks_q <= '0;
									sp_q    <= SPW'(1);
									state_q <= ST_POP;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_POP: begin
					if (sp_q == '0) begin
						state_q <= ST_FINISH;
					end else begin
						sp_q    <= sp_q - SPW'(1);
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (chk_visit) begin
						marks_q[rd_q] <= 1'b1;
						cur_u_q       <= rd_q;
						state_q       <= ST_EMIT;
					end else begin
						state_q <= ST_POP;
					end
				end
				ST_EMIT: begin
					if (!hold_valid_q) begin
						hold_q       <= cur_u_q;
						hold_valid_q <= 1'b1;
						scan_v_q     <= '0;
						state_q      <= ST_SCAN;
					end else if (out_free) begin
						out_q.visited_vertex <= FIELD_W'(VCW'(hold_q) + VCW'(1));
						out_q.last           <= 1'b0;
						hold_q               <= cur_u_q;
						scan_v_q             <= '0;
						state_q              <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (push_en) begin
						sp_q <= sp_q + SPW'(1);
					end
					if (scan_end) begin
						state_q <= ST_POP;
					end else begin
						scan_v_q <= scan_v_q + VW'(1);
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_q.visited_vertex <= FIELD_W'(VCW'(hold_q) + VCW'(1));
						out_q.last           <= 1'b1;
						hold_valid_q         <= 1'b0;
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	`CHK_ALWAYS(a_sp_bound, sp_q <= SPW'(STACK_DEPTH), "stack pointer beyond stack depth")
	`CHK_ALWAYS(a_idle_no_hold, (state_q != ST_IDLE) || !hold_valid_q,
		"held vertex left behind after a walk")
	`CHK_ALWAYS(a_scan_marked, (state_q != ST_SCAN) || marks_q[cur_u_q],
		"scanning neighbours of an unmarked vertex")
	`CHK_NEXT(a_finish_last, (state_q == ST_FINISH) && out_free,
		result_valid && result.last, "walk ended without a final transaction")

endmodule
